// ===== src/raycast_dda_ray_setup_assert.svh =====
// ----------------------------------------------------------------------------
// raycast_dda_ray_setup assertion macros
// shared concurrent assertion forms, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef RAYCAST_DDA_RAY_SETUP_ASSERT_SVH
`define RAYCAST_DDA_RAY_SETUP_ASSERT_SVH

// same-cycle implication
`define RDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rds_pkg.sv =====
// ----------------------------------------------------------------------------
// rds_pkg
// widths, constants and types shared by the ray setup pipeline
// ----------------------------------------------------------------------------
package rds_pkg;

    localparam int MAP_BITS       = 6;
    localparam int FRAC_BITS      = 16;
    localparam int COLUMN_BITS    = 12;

    localparam int POS_BITS       = MAP_BITS + FRAC_BITS;
    localparam int VEC_BITS       = FRAC_BITS + 2;
    localparam int RAY_BITS       = FRAC_BITS + 3;
    localparam int DIST_BITS      = FRAC_BITS + 10;
    localparam int WIDTH_BITS     = COLUMN_BITS + 1;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = POS_BITS;

    // camera divider: (column << (FRAC_BITS+1)) / width
    localparam int CAM_NUM_BITS   = COLUMN_BITS + FRAC_BITS + 1;
    localparam int CAM_BITS       = CAM_NUM_BITS + 1;
    localparam int PROD_BITS      = VEC_BITS + CAM_BITS;
    localparam int RAY_SUM_BITS   = PROD_BITS - FRAC_BITS + 1;

    // length and delta
    localparam int SUM_BITS       = 2 * RAY_BITS;
    localparam int LEN_BITS       = RAY_BITS;
    localparam int DIST_SHIFT     = DIST_BITS - FRAC_BITS;
    localparam int PART_BITS      = FRAC_BITS + 1;
    localparam int SIDE_PROD_BITS = PART_BITS + DIST_BITS;

    localparam logic signed [RAY_BITS-1:0] RAY_MAX_V = {1'b0, {(RAY_BITS-1){1'b1}}};
    localparam logic signed [RAY_BITS-1:0] RAY_MIN_V = {1'b1, {(RAY_BITS-1){1'b0}}};
    localparam logic [DIST_BITS-1:0]       DIST_MAX  = '1;

    localparam logic [POS_BITS-1:0]          RST_VIEWER_X = '0;
    localparam logic [POS_BITS-1:0]          RST_VIEWER_Y = '0;
    localparam logic signed [VEC_BITS-1:0]   RST_FACING_X = VEC_BITS'(65536);
    localparam logic signed [VEC_BITS-1:0]   RST_FACING_Y = '0;
    localparam logic signed [VEC_BITS-1:0]   RST_PLANE_X  = '0;
    localparam logic signed [VEC_BITS-1:0]   RST_PLANE_Y  = VEC_BITS'(43254);
    localparam logic [WIDTH_BITS-1:0]        RST_WIDTH    = WIDTH_BITS'(640);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_VIEWER_X,
        CFG_VIEWER_Y,
        CFG_FACING_X,
        CFG_FACING_Y,
        CFG_PLANE_X,
        CFG_PLANE_Y,
        CFG_SCREEN_WIDTH
    } cfg_index_t;

    typedef struct packed {
        logic signed [RAY_BITS-1:0] x;
        logic signed [RAY_BITS-1:0] y;
    } ray_pair_t;

    // pipeline control between stages
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

// ===== src/rds_cam_div.sv =====
// ----------------------------------------------------------------------------
// rds_cam_div
// pipelined restoring divider, one quotient bit per stage, for camera offset
// ----------------------------------------------------------------------------
module rds_cam_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rds_pkg::pipe_ctl_t                ctl_in,
    input  logic [rds_pkg::COLUMN_BITS-1:0]   col,
    input  logic [rds_pkg::WIDTH_BITS-1:0]    width,
    output logic                              out_valid,
    output logic [rds_pkg::CAM_NUM_BITS-1:0]  quo
);
    import rds_pkg::*;

    localparam int N = CAM_NUM_BITS;

    logic [WIDTH_BITS-1:0] divisor;
    logic                  vld_reg [N];
    logic [WIDTH_BITS-1:0] rem_reg [N];
    logic [N-1:0]          num_reg [N];
    logic [N-1:0]          quo_reg [N];

    // zero width acts as width one
    assign divisor = (width == '0) ? WIDTH_BITS'(1) : width;

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic                  vld_in;
        logic [WIDTH_BITS-1:0] rem_in;
        logic [N-1:0]          num_in;
        logic [N-1:0]          quo_in;
        logic [WIDTH_BITS:0]   cur;
        logic                  ge;
        logic [WIDTH_BITS-1:0] rem_next;
        logic [N-1:0]          quo_next;

        if (i == 0)
        begin : g_head
            assign vld_in = ctl_in.valid;
            assign rem_in = '0;
            assign num_in = {col, (FRAC_BITS+1)'(0)};
            assign quo_in = '0;
        end
        else
        begin : g_body
            assign vld_in = vld_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign num_in = num_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        assign cur      = {rem_in, num_in[N-1-i]};
        assign ge       = cur >= {1'b0, divisor};
        assign rem_next = ge ? WIDTH_BITS'(cur - {1'b0, divisor}) : WIDTH_BITS'(cur);
        assign quo_next = {quo_in[N-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (ctl_in.en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl_in.en)
            begin
                rem_reg[i] <= rem_next;
                num_reg[i] <= num_in;
                quo_reg[i] <= quo_next;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign quo       = quo_reg[N-1];

endmodule

// ===== src/rds_isqrt.sv =====
// ----------------------------------------------------------------------------
// rds_isqrt
// pipelined digit-by-digit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module rds_isqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rds_pkg::pipe_ctl_t              ctl_in,
    input  logic [rds_pkg::SUM_BITS-1:0]    radicand,
    input  rds_pkg::ray_pair_t              rays_in,
    output logic                            out_valid,
    output logic [rds_pkg::LEN_BITS-1:0]    root,
    output rds_pkg::ray_pair_t              rays_out
);
    import rds_pkg::*;

    localparam int N  = LEN_BITS;
    localparam int RW = LEN_BITS + 2;

    logic            vld_reg  [N];
    logic [RW-1:0]   rem_reg  [N];
    logic [N-1:0]    root_reg [N];
    logic [SUM_BITS-1:0] rad_reg [N];
    ray_pair_t       rays_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic                vld_in;
        logic [RW-1:0]       rem_in;
        logic [N-1:0]        root_in;
        logic [SUM_BITS-1:0] rad_in;
        ray_pair_t           rays_cur;
        logic [RW+1:0]       cur;
        logic [RW+1:0]       trial;
        logic                ge;
        logic [RW-1:0]       rem_next;
        logic [N-1:0]        root_next;

        if (i == 0)
        begin : g_head
            assign vld_in   = ctl_in.valid;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign rad_in   = radicand;
            assign rays_cur = rays_in;
        end
        else
        begin : g_body
            assign vld_in   = vld_reg[i-1];
            assign rem_in   = rem_reg[i-1];
            assign root_in  = root_reg[i-1];
            assign rad_in   = rad_reg[i-1];
            assign rays_cur = rays_reg[i-1];
        end

        // bring down the next two radicand bits
        assign cur       = {rem_in, rad_in[2*(N-1-i)+1 -: 2]};
        assign trial     = {RW'(root_in), 2'b01};
        assign ge        = cur >= trial;
        assign rem_next  = ge ? RW'(cur - trial) : RW'(cur);
        assign root_next = {root_in[N-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (ctl_in.en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl_in.en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                rad_reg[i]  <= rad_in;
                rays_reg[i] <= rays_cur;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];
    assign rays_out  = rays_reg[N-1];

endmodule

// ===== src/rds_delta_div.sv =====
// ----------------------------------------------------------------------------
// rds_delta_div
// two-lane pipelined divider: delta = (len << FRAC_BITS) / |ray|, saturating
// ----------------------------------------------------------------------------
module rds_delta_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rds_pkg::pipe_ctl_t              ctl_in,
    input  logic [rds_pkg::LEN_BITS-1:0]    len,
    input  rds_pkg::ray_pair_t              rays_in,
    output logic                            out_valid,
    output logic [rds_pkg::DIST_BITS-1:0]   delta_x,
    output logic [rds_pkg::DIST_BITS-1:0]   delta_y,
    output rds_pkg::ray_pair_t              rays_out
);
    import rds_pkg::*;

    localparam int N = DIST_BITS;

    logic          vld_reg  [N];
    logic [LEN_BITS-1:0] len_reg [N];
    ray_pair_t     rays_reg [N];
    wire  [2*DIST_BITS-1:0] dist_out;

    for (genvar i = 0; i < N; i++)
    begin : g_shared
        logic                vld_in;
        logic [LEN_BITS-1:0] len_in;
        ray_pair_t           rays_cur;

        if (i == 0)
        begin : g_head
            assign vld_in   = ctl_in.valid;
            assign len_in   = len;
            assign rays_cur = rays_in;
        end
        else
        begin : g_body
            assign vld_in   = vld_reg[i-1];
            assign len_in   = len_reg[i-1];
            assign rays_cur = rays_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (ctl_in.en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl_in.en)
            begin
                len_reg[i]  <= len_in;
                rays_reg[i] <= rays_cur;
            end
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic signed [RAY_BITS-1:0] comp;
        logic [RAY_BITS-1:0]        mag_in0;
        logic                       sat_in0;
        logic [RAY_BITS-1:0]        rem_reg [N];
        logic [RAY_BITS-1:0]        mag_reg [N];
        logic [N-1:0]               quo_reg [N];
        logic                       sat_reg [N];

        assign comp    = (l == 0) ? rays_in.x : rays_in.y;
        assign mag_in0 = comp[RAY_BITS-1] ? RAY_BITS'(-comp) : RAY_BITS'(comp);
        // quotient past the field (or a zero divisor) saturates
        assign sat_in0 = {1'b0, len} >= {mag_in0, DIST_SHIFT'(0)};

        for (genvar i = 0; i < N; i++)
        begin : g_stage
            logic [RAY_BITS-1:0] rem_in;
            logic [RAY_BITS-1:0] mag_in;
            logic [N-1:0]        quo_in;
            logic                sat_in;
            logic                nbit;
            logic [RAY_BITS:0]   cur;
            logic                ge;
            logic [RAY_BITS-1:0] rem_next;
            logic [N-1:0]        quo_next;

            if (i == 0)
            begin : g_head
                assign rem_in = RAY_BITS'(len[LEN_BITS-1:DIST_SHIFT]);
                assign mag_in = mag_in0;
                assign quo_in = '0;
                assign sat_in = sat_in0;
            end
            else
            begin : g_body
                assign rem_in = rem_reg[i-1];
                assign mag_in = mag_reg[i-1];
                assign quo_in = quo_reg[i-1];
                assign sat_in = sat_reg[i-1];
            end

            // numerator bit N-1-i of {len, FRAC_BITS zeros}
            if (N - 1 - i >= FRAC_BITS)
            begin : g_len_bit
                if (i == 0)
                begin : g_from_port
                    assign nbit = len[N - 1 - FRAC_BITS];
                end
                else
                begin : g_from_reg
                    assign nbit = len_reg[i-1][N - 1 - i - FRAC_BITS];
                end
            end
            else
            begin : g_zero_bit
                assign nbit = 1'b0;
            end

            assign cur      = {rem_in, nbit};
            assign ge       = cur >= {1'b0, mag_in};
            assign rem_next = ge ? RAY_BITS'(cur - {1'b0, mag_in}) : RAY_BITS'(cur);
            assign quo_next = {quo_in[N-2:0], ge};

            always_ff @(posedge clk)
            begin
                if (ctl_in.en)
                begin
                    rem_reg[i] <= rem_next;
                    mag_reg[i] <= mag_in;
                    quo_reg[i] <= quo_next;
                    sat_reg[i] <= sat_in;
                end
            end
        end

        assign dist_out[l*DIST_BITS +: DIST_BITS] = sat_reg[N-1] ? DIST_MAX : quo_reg[N-1];
    end

    assign out_valid = vld_reg[N-1];
    assign delta_x   = dist_out[DIST_BITS-1:0];
    assign delta_y   = dist_out[2*DIST_BITS-1:DIST_BITS];
    assign rays_out  = rays_reg[N-1];

endmodule

// ===== src/raycast_dda_ray_setup.sv =====
// ----------------------------------------------------------------------------
// raycast_dda_ray_setup
// per-column ray setup for a grid dda raycaster, fully pipelined
// ----------------------------------------------------------------------------
//  channel   signals                         direction  beat
//  column    column_valid/ready, column      in         one screen column
//  result    result_valid/ready, 10 fields   out        one ray setup
//  cfg       cfg_valid/ready, index, data    in         one register write
//
//  one column enters per cycle while the result port is not stalled; a column
//  accepted passes 80 register stages before it shows on the result port
//  stages: input reg, 29-stage camera divider, multiply, ray add, squares,
//  square sum, 19-stage square root, 26-stage delta divider, output reg
//  rst_n clears all valid bits and loads the register reset values
//  a result held at the output freezes the whole pipeline; nothing is lost
//  cfg_ready is always high; a write takes effect from the next cycle
// ----------------------------------------------------------------------------
module raycast_dda_ray_setup (
    input  logic                                clk,
    input  logic                                rst_n,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rds_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rds_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // column channel
    input  logic                                column_valid,
    output logic                                column_ready,
    input  logic [rds_pkg::COLUMN_BITS-1:0]     column,
    // result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [rds_pkg::MAP_BITS-1:0]        cell_x,
    output logic [rds_pkg::MAP_BITS-1:0]        cell_y,
    output logic                                step_x_neg,
    output logic                                step_y_neg,
    output logic signed [rds_pkg::RAY_BITS-1:0] ray_x,
    output logic signed [rds_pkg::RAY_BITS-1:0] ray_y,
    output logic [rds_pkg::DIST_BITS-1:0]       delta_x,
    output logic [rds_pkg::DIST_BITS-1:0]       delta_y,
    output logic [rds_pkg::DIST_BITS-1:0]       side_x,
    output logic [rds_pkg::DIST_BITS-1:0]       side_y
);
    import rds_pkg::*;

    `include "raycast_dda_ray_setup_assert.svh"

    localparam logic signed [CAM_BITS-1:0]  CAM_ONE  = CAM_BITS'(2**FRAC_BITS);
    localparam logic [PART_BITS-1:0]        PART_ONE = PART_BITS'(2**FRAC_BITS);

    // config registers
    logic [POS_BITS-1:0]          viewer_x_reg, viewer_y_reg;
    logic signed [VEC_BITS-1:0]   facing_x_reg, facing_y_reg;
    logic signed [VEC_BITS-1:0]   plane_x_reg, plane_y_reg;
    logic [WIDTH_BITS-1:0]        width_reg;

    // global advance: the pipeline moves whenever the output slot frees up
    logic       en;
    pipe_ctl_t  col_ctl, sq_ctl, len_ctl;

    // stage registers
    logic                       col_vld_reg;
    logic [COLUMN_BITS-1:0]     col_reg;
    logic                       cam_vld;
    logic [CAM_NUM_BITS-1:0]    cam_quo;
    logic signed [CAM_BITS-1:0] cam;
    logic                       prod_vld_reg;
    logic signed [PROD_BITS-1:0] prod_x_reg, prod_y_reg;
    logic                       ray_vld_reg;
    ray_pair_t                  ray_reg;
    logic                       sq_vld_reg;
    logic [SUM_BITS-1:0]        sqx_reg, sqy_reg;
    ray_pair_t                  sq_rays_reg;
    logic                       sum_vld_reg;
    logic [SUM_BITS-1:0]        sum_reg;
    ray_pair_t                  sum_rays_reg;
    logic                       len_vld;
    logic [LEN_BITS-1:0]        len;
    ray_pair_t                  len_rays;
    logic                       dlt_vld;
    logic [DIST_BITS-1:0]       dlt_x, dlt_y;
    ray_pair_t                  dlt_rays;

    // output register
    logic                       res_valid_reg;
    logic [MAP_BITS-1:0]        cell_x_reg, cell_y_reg;
    logic signed [RAY_BITS-1:0] ray_x_reg, ray_y_reg;
    logic [DIST_BITS-1:0]       delta_x_reg, delta_y_reg, side_x_reg, side_y_reg;
    logic [DIST_BITS-1:0]       side_x_next, side_y_next;
    logic signed [RAY_BITS-1:0] ray_x_next, ray_y_next;
    logic signed [SUM_BITS-1:0] sqx_next, sqy_next;

    // ray = facing + floor(plane * camera / 2^FRAC_BITS), saturated
    function automatic logic signed [RAY_BITS-1:0] sat_ray(
        input logic signed [VEC_BITS-1:0]  base,
        input logic signed [PROD_BITS-1:0] prod
    );
        logic signed [RAY_SUM_BITS-1:0] s;
        s = RAY_SUM_BITS'(base) + RAY_SUM_BITS'(prod >>> FRAC_BITS);
        if (s > RAY_SUM_BITS'(RAY_MAX_V))
            return RAY_MAX_V;
        else if (s < RAY_SUM_BITS'(RAY_MIN_V))
            return RAY_MIN_V;
        else
            return RAY_BITS'(s);
    endfunction

    // side = part * delta / 2^FRAC_BITS, part picked by step direction
    function automatic logic [DIST_BITS-1:0] side_dist(
        input logic [FRAC_BITS-1:0]  frac,
        input logic                  neg,
        input logic [DIST_BITS-1:0]  delta
    );
        logic [PART_BITS-1:0]      part;
        logic [SIDE_PROD_BITS-1:0] p;
        part = neg ? {1'b0, frac} : PART_ONE - {1'b0, frac};
        p    = SIDE_PROD_BITS'(part) * SIDE_PROD_BITS'(delta);
        if (p[SIDE_PROD_BITS-1:FRAC_BITS+DIST_BITS] != '0)
            return DIST_MAX;
        else
            return p[FRAC_BITS +: DIST_BITS];
    endfunction

    assign cfg_ready    = 1'b1;
    assign en           = !res_valid_reg || result_ready;
    assign column_ready = en;

    // config writes; unknown index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            viewer_x_reg <= RST_VIEWER_X;
            viewer_y_reg <= RST_VIEWER_Y;
            facing_x_reg <= RST_FACING_X;
            facing_y_reg <= RST_FACING_Y;
            plane_x_reg  <= RST_PLANE_X;
            plane_y_reg  <= RST_PLANE_Y;
            width_reg    <= RST_WIDTH;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_VIEWER_X:     viewer_x_reg <= cfg_data[POS_BITS-1:0];
                CFG_VIEWER_Y:     viewer_y_reg <= cfg_data[POS_BITS-1:0];
                CFG_FACING_X:     facing_x_reg <= cfg_data[VEC_BITS-1:0];
                CFG_FACING_Y:     facing_y_reg <= cfg_data[VEC_BITS-1:0];
                CFG_PLANE_X:      plane_x_reg  <= cfg_data[VEC_BITS-1:0];
                CFG_PLANE_Y:      plane_y_reg  <= cfg_data[VEC_BITS-1:0];
                CFG_SCREEN_WIDTH: width_reg    <= cfg_data[WIDTH_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // valid bits of the top-level stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_vld_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            ray_vld_reg   <= 1'b0;
            sq_vld_reg    <= 1'b0;
            sum_vld_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            col_vld_reg   <= column_valid;
            prod_vld_reg  <= cam_vld;
            ray_vld_reg   <= prod_vld_reg;
            sq_vld_reg    <= ray_vld_reg;
            sum_vld_reg   <= sq_vld_reg;
            res_valid_reg <= dlt_vld;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg <= column;
        end
    end

    assign col_ctl = '{en: en, valid: col_vld_reg};

    // camera offset quotient, one bit per stage
    rds_cam_div u_cam_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (col_ctl),
        .col       (col_reg),
        .width     (width_reg),
        .out_valid (cam_vld),
        .quo       (cam_quo)
    );

    // camera in [-1, 1) nominal, extrapolated beyond the window
    assign cam = $signed({1'b0, cam_quo}) - CAM_ONE;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg <= PROD_BITS'(plane_x_reg) * PROD_BITS'(cam);
            prod_y_reg <= PROD_BITS'(plane_y_reg) * PROD_BITS'(cam);
        end
    end

    assign ray_x_next = sat_ray(facing_x_reg, prod_x_reg);
    assign ray_y_next = sat_ray(facing_y_reg, prod_y_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ray_reg.x <= ray_x_next;
            ray_reg.y <= ray_y_next;
        end
    end

    // squared length, one multiply per axis then the sum
    assign sqx_next = SUM_BITS'(ray_reg.x) * SUM_BITS'(ray_reg.x);
    assign sqy_next = SUM_BITS'(ray_reg.y) * SUM_BITS'(ray_reg.y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg      <= $unsigned(sqx_next);
            sqy_reg      <= $unsigned(sqy_next);
            sq_rays_reg  <= ray_reg;
            sum_reg      <= sqx_reg + sqy_reg;
            sum_rays_reg <= sq_rays_reg;
        end
    end

    assign sq_ctl = '{en: en, valid: sum_vld_reg};

    rds_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (sq_ctl),
        .radicand  (sum_reg),
        .rays_in   (sum_rays_reg),
        .out_valid (len_vld),
        .root      (len),
        .rays_out  (len_rays)
    );

    assign len_ctl = '{en: en, valid: len_vld};

    rds_delta_div u_delta_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (len_ctl),
        .len       (len),
        .rays_in   (len_rays),
        .out_valid (dlt_vld),
        .delta_x   (dlt_x),
        .delta_y   (dlt_y),
        .rays_out  (dlt_rays)
    );

    assign side_x_next = side_dist(viewer_x_reg[FRAC_BITS-1:0], dlt_rays.x[RAY_BITS-1], dlt_x);
    assign side_y_next = side_dist(viewer_y_reg[FRAC_BITS-1:0], dlt_rays.y[RAY_BITS-1], dlt_y);

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_x_reg  <= viewer_x_reg[POS_BITS-1:FRAC_BITS];
            cell_y_reg  <= viewer_y_reg[POS_BITS-1:FRAC_BITS];
            ray_x_reg   <= dlt_rays.x;
            ray_y_reg   <= dlt_rays.y;
            delta_x_reg <= dlt_x;
            delta_y_reg <= dlt_y;
            side_x_reg  <= side_x_next;
            side_y_reg  <= side_y_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign cell_x       = cell_x_reg;
    assign cell_y       = cell_y_reg;
    assign step_x_neg   = ray_x_reg[RAY_BITS-1];
    assign step_y_neg   = ray_y_reg[RAY_BITS-1];
    assign ray_x        = ray_x_reg;
    assign ray_y        = ray_y_reg;
    assign delta_x      = delta_x_reg;
    assign delta_y      = delta_y_reg;
    assign side_x       = side_x_reg;
    assign side_y       = side_y_reg;

    // a zero ray component never divides
    `RDS_ASSERT_NOW(a_zero_ray_sat, result_valid && ray_x == '0, delta_x == DIST_MAX, "zero ray x without saturated delta")
    // length is at least the component, so delta is at least one
    `RDS_ASSERT_NOW(a_delta_floor, result_valid, delta_x[DIST_BITS-1:FRAC_BITS] != '0 && delta_y[DIST_BITS-1:FRAC_BITS] != '0, "delta below one cell")
    // the partial step never exceeds one full cell
    `RDS_ASSERT_NOW(a_side_le_delta, result_valid, side_x <= delta_x && side_y <= delta_y, "side distance above delta")
    // a stalled pipeline holds its front stage
    `RDS_ASSERT_NEXT(a_stall_hold, !en && col_vld_reg, col_vld_reg && $stable(col_reg), "front stage moved during stall")

endmodule
